[rtl/hrlp_pkg.sv]
package hrlp_pkg;

  // Character codes
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7A;
  localparam logic [7:0] ChUpE   = 8'h45;
  localparam logic [7:0] ChUpG   = 8'h47;
  localparam logic [7:0] ChUpH   = 8'h48;
  localparam logic [7:0] ChUpO   = 8'h4F;
  localparam logic [7:0] ChUpP   = 8'h50;
  localparam logic [7:0] ChUpS   = 8'h53;
  localparam logic [7:0] ChUpT   = 8'h54;

  // Result kind codes
  localparam logic KindUrl     = 1'b0;
  localparam logic KindVerdict = 1'b1;

  // Method codes
  localparam logic MethodGet  = 1'b0;
  localparam logic MethodPost = 1'b1;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] url_byte;
    logic       rejected;
    logic       method;
    logic [3:0] major_digit;
    logic [3:0] minor_digit;
  } result_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c >= ChLowA && c <= ChLowZ) u = c - 8'h20;
    return u;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return (c == ChNul) || (c == ChCr) || (c == ChLf);
  endfunction

endpackage

[rtl/http_request_line_parser_top.sv]
// Channel | Direction | Handshake              | Word
// in      | input     | in_valid_i / in_stall_o   | in_byte_i
// out     | output    | out_valid_o / out_stall_i | kind_o url_byte_o rejected_o method_o
//         |           |                           | major_digit_o minor_digit_o
// One byte per clock sustained while the output word is not stalled; the result passes
// through the input register, then the parser step into the result register.
// Reset (rst_ni low) returns the parser to expecting the method's first letter.
// A byte that yields no result retires even while the output word is stalled;
// a byte that yields a result waits in the input register until it can retire.
module http_request_line_parser_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       kind_o,
  output logic [7:0] url_byte_o,
  output logic       rejected_o,
  output logic       method_o,
  output logic [3:0] major_digit_o,
  output logic [3:0] minor_digit_o
);
  import hrlp_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  result_t    out_q;
  result_t    res;
  logic       advance;
  logic       accept;

  hrlp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_en_i(advance),
    .byte_i   (in_byte_q),
    .res_o    (res)
  );

  assign advance    = in_valid_q && (!res.valid || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (advance && res.valid) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_byte_q <= in_byte_i;
    if (advance && res.valid) out_q <= res;
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_q.kind;
  assign url_byte_o    = out_q.url_byte;
  assign rejected_o    = out_q.rejected;
  assign method_o      = out_q.method;
  assign major_digit_o = out_q.major_digit;
  assign minor_digit_o = out_q.minor_digit;

endmodule

[rtl/hrlp_parser.sv]
module hrlp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_en_i,
  input  logic [7:0]        byte_i,
  output hrlp_pkg::result_t res_o
);
  import hrlp_pkg::*;

  localparam logic [4:0] PhM0     = 5'd0;
  localparam logic [4:0] PhG1     = 5'd1;
  localparam logic [4:0] PhG2     = 5'd2;
  localparam logic [4:0] PhP1     = 5'd3;
  localparam logic [4:0] PhP2     = 5'd4;
  localparam logic [4:0] PhP3     = 5'd5;
  localparam logic [4:0] PhNeedBl = 5'd6;
  localparam logic [4:0] PhSkip1  = 5'd7;
  localparam logic [4:0] PhUrl    = 5'd8;
  localparam logic [4:0] PhSkip2  = 5'd9;
  localparam logic [4:0] PhT1     = 5'd10;
  localparam logic [4:0] PhT2     = 5'd11;
  localparam logic [4:0] PhP      = 5'd12;
  localparam logic [4:0] PhSlash  = 5'd13;
  localparam logic [4:0] PhMaj    = 5'd14;
  localparam logic [4:0] PhDot    = 5'd15;
  localparam logic [4:0] PhMin    = 5'd16;
  localparam logic [4:0] PhTail   = 5'd17;
  localparam logic [4:0] PhErr    = 5'd18;

  logic [4:0] phase_q, phase_d;
  logic       method_q, method_d;
  logic [3:0] major_q, major_d;
  logic [3:0] minor_q, minor_d;
  logic [7:0] up;
  logic       blank;
  logic       digit;

  assign up    = upcase(byte_i);
  assign blank = is_blank(byte_i);
  assign digit = (byte_i >= ChZero) && (byte_i <= ChNine);

  always_comb begin
    phase_d  = phase_q;
    method_d = method_q;
    major_d  = major_q;
    minor_d  = minor_q;
    res_o    = '0;

    if (is_term(byte_i)) begin
      res_o.valid    = 1'b1;
      res_o.kind     = KindVerdict;
      res_o.rejected = (phase_q != PhTail);
      if (phase_q == PhTail) begin
        res_o.method      = method_q;
        res_o.major_digit = major_q;
        res_o.minor_digit = minor_q;
      end
      phase_d  = PhM0;
      method_d = MethodGet;
      major_d  = '0;
      minor_d  = '0;
    end else begin
      case (phase_q)
        PhM0: begin
          if (up == ChUpG) begin
            method_d = MethodGet;
            phase_d  = PhG1;
          end else if (up == ChUpP) begin
            method_d = MethodPost;
            phase_d  = PhP1;
          end else begin
            phase_d = PhErr;
          end
        end
        PhG1:     phase_d = (up == ChUpE) ? PhG2 : PhErr;
        PhG2:     phase_d = (up == ChUpT) ? PhNeedBl : PhErr;
        PhP1:     phase_d = (up == ChUpO) ? PhP2 : PhErr;
        PhP2:     phase_d = (up == ChUpS) ? PhP3 : PhErr;
        PhP3:     phase_d = (up == ChUpT) ? PhNeedBl : PhErr;
        PhNeedBl: phase_d = blank ? PhSkip1 : PhErr;
        PhSkip1, PhUrl: begin
          if (blank) begin
            // first blank after the URL ends it
            if (phase_q == PhUrl) phase_d = PhSkip2;
          end else begin
            phase_d        = PhUrl;
            res_o.valid    = 1'b1;
            res_o.kind     = KindUrl;
            res_o.url_byte = byte_i;
          end
        end
        PhSkip2: begin
          if (!blank) phase_d = (up == ChUpH) ? PhT1 : PhErr;
        end
        PhT1:    phase_d = (up == ChUpT) ? PhT2 : PhErr;
        PhT2:    phase_d = (up == ChUpT) ? PhP : PhErr;
        PhP:     phase_d = (up == ChUpP) ? PhSlash : PhErr;
        PhSlash: phase_d = (byte_i == ChSlash) ? PhMaj : PhErr;
        PhMaj: begin
          if (digit) begin
            major_d = byte_i[3:0];  // ASCII digit value is its low nibble
            phase_d = PhDot;
          end else begin
            phase_d = PhErr;
          end
        end
        PhDot: phase_d = (byte_i == ChDot) ? PhMin : PhErr;
        PhMin: begin
          if (digit) begin
            minor_d = byte_i[3:0];
            phase_d = PhTail;
          end else begin
            phase_d = PhErr;
          end
        end
        PhTail: begin
          if (!blank) phase_d = PhErr;
        end
        default: phase_d = PhErr;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhM0;
      method_q <= MethodGet;
      major_q  <= '0;
      minor_q  <= '0;
    end else if (step_en_i) begin
      phase_q  <= phase_d;
      method_q <= method_d;
      major_q  <= major_d;
      minor_q  <= minor_d;
    end
  end

endmodule

[rtl/hrlp_checker.sv]
module hrlp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] in_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       kind_o,
  input logic [7:0] url_byte_o,
  input logic       rejected_o,
  input logic       method_o,
  input logic [3:0] major_digit_o,
  input logic [3:0] minor_digit_o
);
  import hrlp_pkg::*;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(url_byte_o)
      && $stable(rejected_o) && $stable(method_o) && $stable(major_digit_o)
      && $stable(minor_digit_o))
    else $error("output word changed while stalled");

  // URL word never carries blank or terminator, verdict fields are zero
  a_url_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindUrl |-> !is_blank(url_byte_o) && !is_term(url_byte_o)
      && !rejected_o && !method_o && major_digit_o == 4'd0 && minor_digit_o == 4'd0)
    else $error("bad URL word");

  // every verdict has decimal digits, no URL byte
  a_verdict_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindVerdict |-> url_byte_o == 8'd0
      && major_digit_o <= 4'd9 && minor_digit_o <= 4'd9)
    else $error("bad verdict word");

  // rejected verdict carries no method or version
  a_verdict_rej: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindVerdict && rejected_o |->
      !method_o && major_digit_o == 4'd0 && minor_digit_o == 4'd0)
    else $error("rejected verdict carries fields");

  // a terminator taken with a free output and then an unstalled sink shows a verdict
  a_term_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && is_term(in_byte_i) && !out_valid_o
      ##1 !out_stall_i |=> out_valid_o && kind_o == KindVerdict)
    else $error("terminator did not yield a verdict");

endmodule

bind http_request_line_parser_top hrlp_checker u_hrlp_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import hrlp_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailCycles = 8;
  localparam logic [7:0]  ChUpA      = 8'h41;
  localparam logic [7:0]  ChUpZ      = 8'h5A;
  localparam logic [7:0]  CaseBit    = 8'h20;
  localparam logic [7:0]  ChTilde    = 8'h7E;
  localparam logic [7:0]  ChAllOnes  = 8'hFF;

  typedef enum logic [4:0] {
    StMethod0, StGet1, StGet2, StPost1, StPost2, StPost3, StNeedBlank, StSkipLead,
    StUrl, StSkipMid, StProtoT1, StProtoT2, StProtoP, StProtoSlash, StMajor, StDot,
    StMinor, StTail, StError
  } line_phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] url_byte;
    logic       rejected;
    logic       method;
    logic [3:0] major_digit;
    logic [3:0] minor_digit;
  } parser_word_t;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       in_valid_i = 1'b0;
  logic [7:0] in_byte_i  = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       kind_o;
  logic [7:0] url_byte_o;
  logic       rejected_o;
  logic       method_o;
  logic [3:0] major_digit_o;
  logic [3:0] minor_digit_o;

  // predictor state
  line_phase_e phase_q  = StMethod0;
  logic        method_q = MethodGet;
  logic [3:0]  major_q  = 4'd0;
  logic [3:0]  minor_q  = 4'd0;

  parser_word_t pending_words[$];
  logic [7:0]   line_buf[$];

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned hold_reqs     = 0;
  int unsigned hold_done     = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;
  int unsigned word_errors   = 0;
  int unsigned bytes_sent    = 0;
  int unsigned lines_sent    = 0;
  int unsigned url_words     = 0;
  int unsigned verdicts      = 0;
  int unsigned good_lines    = 0;

  http_request_line_parser_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .url_byte_o   (url_byte_o),
    .rejected_o   (rejected_o),
    .method_o     (method_o),
    .major_digit_o(major_digit_o),
    .minor_digit_o(minor_digit_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic is_ws(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

  function automatic logic ends_line(input logic [7:0] c);
    return (c == ChNul) || (c == ChCr) || (c == ChLf);
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= ChLowA && c <= ChLowZ) ? c - CaseBit : c;
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  // Advances the line state by one byte; returns 1 when the byte yields a word.
  function automatic logic step_parser(input logic [7:0] c, output parser_word_t w);
    logic [7:0]  u;
    line_phase_e nxt;
    w = '0;
    u = fold_case(c);
    if (ends_line(c)) begin
      w.kind = KindVerdict;
      w.rejected = (phase_q != StTail);
      if (phase_q == StTail) begin
        w.method = method_q;
        w.major_digit = major_q;
        w.minor_digit = minor_q;
      end
      phase_q = StMethod0;
      method_q = MethodGet;
      major_q = 4'd0;
      minor_q = 4'd0;
      return 1'b1;
    end
    nxt = StError;
    case (phase_q)
      StMethod0: begin
        if (u == ChUpG) begin
          method_q = MethodGet;
          nxt = StGet1;
        end else if (u == ChUpP) begin
          method_q = MethodPost;
          nxt = StPost1;
        end
      end
      StGet1:       if (u == ChUpE) nxt = StGet2;
      StGet2:       if (u == ChUpT) nxt = StNeedBlank;
      StPost1:      if (u == ChUpO) nxt = StPost2;
      StPost2:      if (u == ChUpS) nxt = StPost3;
      StPost3:      if (u == ChUpT) nxt = StNeedBlank;
      StNeedBlank:  if (is_ws(c)) nxt = StSkipLead;
      StSkipLead, StUrl: begin
        if (is_ws(c)) begin
          nxt = (phase_q == StUrl) ? StSkipMid : StSkipLead;
        end else begin
          phase_q = StUrl;
          w.kind = KindUrl;
          w.url_byte = c;
          return 1'b1;
        end
      end
      StSkipMid: begin
        if (is_ws(c)) nxt = StSkipMid;
        else if (u == ChUpH) nxt = StProtoT1;
      end
      StProtoT1:    if (u == ChUpT) nxt = StProtoT2;
      StProtoT2:    if (u == ChUpT) nxt = StProtoP;
      StProtoP:     if (u == ChUpP) nxt = StProtoSlash;
      StProtoSlash: if (c == ChSlash) nxt = StMajor;
      StMajor: begin
        if (is_num(c)) begin
          major_q = 4'(c - ChZero);
          nxt = StDot;
        end
      end
      StDot:        if (c == ChDot) nxt = StMinor;
      StMinor: begin
        if (is_num(c)) begin
          minor_q = 4'(c - ChZero);
          nxt = StTail;
        end
      end
      StTail:       if (is_ws(c)) nxt = StTail;
      default:      nxt = StError;
    endcase
    phase_q = nxt;
    return 1'b0;
  endfunction

  // Offers one byte and returns at the edge that accepts it.
  task automatic send_word(input logic [7:0] b);
    parser_word_t w;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    if (step_parser(b, w)) pending_words.push_back(w);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_word(line_buf[i]);
    lines_sent++;
  endtask

  function automatic void push_text(input string s, input logic mix_case);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix_case && c >= ChUpA && c <= ChUpZ && $urandom_range(1)) c = c + CaseBit;
      line_buf.push_back(c);
    end
  endfunction

  function automatic void push_blanks(input int unsigned lo, input int unsigned hi);
    repeat ($urandom_range(hi, lo)) line_buf.push_back($urandom_range(1) ? ChSpace : ChTab);
  endfunction

  function automatic void push_url(input int unsigned max_len);
    logic [7:0] c;
    repeat ($urandom_range(max_len, 1)) begin
      do c = 8'($urandom_range(255)); while (is_ws(c) || ends_line(c));
      line_buf.push_back(c);
    end
  endfunction

  function automatic logic [7:0] pick_term();
    case ($urandom_range(2))
      0:       return ChNul;
      1:       return ChCr;
      default: return ChLf;
    endcase
  endfunction

  // Mostly well-formed lines with random content; some corrupted, cut short or noise.
  function automatic void make_line();
    int unsigned style;
    int unsigned pos;
    line_buf.delete();
    style = $urandom_range(99);
    if (style < 8) begin
      repeat ($urandom_range(12, 1)) line_buf.push_back(8'($urandom_range(255)));
    end else begin
      push_text($urandom_range(1) ? "POST" : "GET", 1'b1);
      push_blanks(1, 3);
      push_url(($urandom_range(9) == 0) ? 16 : 6);
      push_blanks(1, 2);
      push_text("HTTP/", 1'b1);
      line_buf.push_back(ChZero + 8'($urandom_range(9)));
      line_buf.push_back(ChDot);
      line_buf.push_back(ChZero + 8'($urandom_range(9)));
      push_blanks(0, 2);
      pos = $urandom_range(line_buf.size() - 1);
      if (style < 25) begin
        line_buf[pos] = 8'($urandom_range(255));
      end else if (style < 33) begin
        while (line_buf.size() > pos) void'(line_buf.pop_back());
      end
    end
    line_buf.push_back(pick_term());
  endfunction

  // Drops the offer, then waits until every predicted word has come out.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    // empty line
    line_buf.delete();
    line_buf.push_back(ChLf);
    send_line();
    // method run straight into a non-blank
    line_buf.delete();
    push_text("GET", 1'b0);
    line_buf.push_back(ChAllOnes);
    line_buf.push_back(ChNul);
    send_line();
    // mixed case POST, tabs before the URL, trailing blank
    line_buf.delete();
    push_text("pOsT\t\t", 1'b0);
    line_buf.push_back(ChTilde);
    push_text(" HTTP/0.9 ", 1'b0);
    line_buf.push_back(ChCr);
    send_line();
    wait_drain();
  endtask

  task automatic test_random_lines(input int unsigned budget, input int unsigned src_pct,
                                   input int unsigned sink_pct);
    int unsigned start;
    src_idle_pct = src_pct;
    sink_idle_pct <= sink_pct;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      make_line();
      send_line();
    end
  endtask

  // Sink holds off while a long URL streams in, so the input side backs up.
  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    hold_reqs <= hold_reqs + 1;
    line_buf.delete();
    push_text("GET ", 1'b1);
    push_url(1);
    repeat (40) push_url(1);
    push_text(" HTTP/1.1", 1'b1);
    line_buf.push_back(ChLf);
    send_line();
    wait_drain();
  endtask

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_done) begin
      out_stall_i <= 1'b1;
      hold_left <= HoldCycles;
      hold_done <= hold_reqs;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      word_errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i) begin
    parser_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        word_errors++;
        $display("%0t: unexpected word: expected none, got kind %0b byte %0h rej %0b",
                 $time, kind_o, url_byte_o, rejected_o);
      end else begin
        exp_w = pending_words.pop_front();
        check_field("kind", 8'(exp_w.kind), 8'(kind_o));
        check_field("url_byte", exp_w.url_byte, url_byte_o);
        check_field("rejected", 8'(exp_w.rejected), 8'(rejected_o));
        check_field("method", 8'(exp_w.method), 8'(method_o));
        check_field("major_digit", 8'(exp_w.major_digit), 8'(major_digit_o));
        check_field("minor_digit", 8'(exp_w.minor_digit), 8'(minor_digit_o));
        if (exp_w.kind == KindUrl) url_words++;
        else verdicts++;
        if (exp_w.kind == KindVerdict && !exp_w.rejected) good_lines++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d words outstanding", $time, pending_words.size());
      $display("http_request_line_parser_top regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_lines(420, 31, 52);
    test_random_lines(420, 52, 31);
    test_random_lines(420, 0, 0);
    test_backpressure();
    wait_drain();
    repeat (TailCycles) @(posedge clk_i);
    $display("Sent %0d bytes in %0d lines; checked %0d URL words and %0d verdicts",
             bytes_sent, lines_sent, url_words, verdicts);
    $display("%0d lines accepted, the rest rejected; one long sink hold-off", good_lines);
    if (word_errors == 0 && pending_words.size() == 0) begin
      $display("http_request_line_parser_top regression: pass");
    end else begin
      $display("http_request_line_parser_top regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/hrlp_pkg.sv
rtl/hrlp_parser.sv
rtl/http_request_line_parser_top.sv
rtl/hrlp_checker.sv
tb/sv/tb_top.sv
